FILE: rtl/hdb_pkg.sv
// ----------------------------------------------------------------------------
// hdb_pkg: shared types and constants for the HDLC byte destuff receiver
// Flag/escape bytes, receive modes, event kinds and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package hdb_pkg;

    // Default frame size limit (payload bytes)
    localparam int unsigned MAX_FRAME_DEF = 4096;

    // Field widths
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned INDEX_W  = 12;
    localparam int unsigned COUNT_W  = 13;
    localparam int unsigned EVENT_W  = 2;

    // Framing bytes
    localparam logic [BYTE_W-1:0] FLAG_BYTE = 8'h7E;
    localparam logic [BYTE_W-1:0] ESC_BYTE  = 8'h7D;
    localparam logic [BYTE_W-1:0] ESC_XOR   = 8'h20;

    // Largest value a count register can hold
    localparam int unsigned COUNT_MAX = (1 << COUNT_W) - 1;

    // Receive modes
    typedef enum logic [2:0] {
        MODE_UNSYNCED = 3'd0,
        MODE_SYNCED   = 3'd1,
        MODE_INFRAME  = 3'd2,
        MODE_ESCAPE   = 3'd3,
        MODE_DISCARD  = 3'd4
    } rx_mode_t;

    // Event kinds
    typedef enum logic [EVENT_W-1:0] {
        EV_NONE     = 2'd0,
        EV_PAYLOAD  = 2'd1,
        EV_END      = 2'd2,
        EV_OVERFLOW = 2'd3
    } event_t;

    // One result item
    typedef struct packed {
        event_t               event_res;
        logic [BYTE_W-1:0]    payload_byte;
        logic [INDEX_W-1:0]   byte_index;
        logic [COUNT_W-1:0]   frame_length;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/hdb_in_stage.sv
// ----------------------------------------------------------------------------
// hdb_in_stage: input register of the receiver
// Holds one received byte until the deframer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module hdb_in_stage (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [hdb_pkg::BYTE_W-1:0] s_tdata,
    input  wire logic                       out_free,   // output stage can load
    output logic                            step,       // byte moves on this cycle
    output logic [hdb_pkg::BYTE_W-1:0]      rx_byte
);

    logic                       valid_reg;
    logic                       valid_next;
    logic [hdb_pkg::BYTE_W-1:0] byte_reg;

    // Byte leaves when the output side has room
    assign step     = valid_reg && out_free;
    assign s_tready = !valid_reg || step;
    assign rx_byte  = byte_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready)
        begin
            valid_next = 1'b1;
        end
        else if (step)
        begin
            valid_next = 1'b0;
        end
    end

    // Occupancy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Byte holding register
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            byte_reg <= s_tdata;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/hdb_deframer.sv
// ----------------------------------------------------------------------------
// hdb_deframer: receive mode machine and byte counter
// Destuffs one byte per step and builds the result for the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module hdb_deframer #(
    parameter int unsigned MAX_FRAME = hdb_pkg::MAX_FRAME_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        step,
    input  wire logic [hdb_pkg::BYTE_W-1:0]  rx_byte,
    input  wire logic                        cfg_wr_en,
    input  wire logic [hdb_pkg::COUNT_W-1:0] cfg_wr_data,
    output hdb_pkg::result_t                 result
);

    // Clamp value of the limit, fits the count width
    localparam int unsigned CLAMP_VAL =
        (MAX_FRAME > hdb_pkg::COUNT_MAX) ? hdb_pkg::COUNT_MAX : MAX_FRAME;
    localparam logic [hdb_pkg::COUNT_W-1:0] CLAMP = CLAMP_VAL[hdb_pkg::COUNT_W-1:0];

    hdb_pkg::rx_mode_t           mode_reg;
    hdb_pkg::rx_mode_t           mode_next;
    logic [hdb_pkg::COUNT_W-1:0] count_reg;
    logic [hdb_pkg::COUNT_W-1:0] count_next;
    logic [hdb_pkg::COUNT_W-1:0] max_len_reg;

    logic [hdb_pkg::COUNT_W-1:0] limit;
    logic                        full;
    logic                        is_flag;
    logic                        is_esc;
    logic [hdb_pkg::BYTE_W-1:0]  data_byte;

    // Shared decode
    assign limit     = (max_len_reg > CLAMP) ? CLAMP : max_len_reg;
    assign full      = (count_reg >= limit);
    assign is_flag   = (rx_byte == hdb_pkg::FLAG_BYTE);
    assign is_esc    = (rx_byte == hdb_pkg::ESC_BYTE);
    assign data_byte = (mode_reg == hdb_pkg::MODE_ESCAPE) ? (rx_byte ^ hdb_pkg::ESC_XOR)
                                                          : rx_byte;

    // Next mode
    always_comb
    begin
        mode_next = mode_reg;
        case (mode_reg)
            hdb_pkg::MODE_UNSYNCED:
            begin
                if (is_flag)
                begin
                    mode_next = hdb_pkg::MODE_SYNCED;
                end
            end
            hdb_pkg::MODE_SYNCED, hdb_pkg::MODE_INFRAME:
            begin
                if (is_flag)
                begin
                    // repeated flag keeps synced; closing flag ends the frame
                    mode_next = (mode_reg == hdb_pkg::MODE_INFRAME) ? hdb_pkg::MODE_UNSYNCED
                                                                    : hdb_pkg::MODE_SYNCED;
                end
                else if (is_esc)
                begin
                    mode_next = hdb_pkg::MODE_ESCAPE;
                end
                else
                begin
                    mode_next = full ? hdb_pkg::MODE_DISCARD : hdb_pkg::MODE_INFRAME;
                end
            end
            hdb_pkg::MODE_ESCAPE:
            begin
                mode_next = full ? hdb_pkg::MODE_DISCARD : hdb_pkg::MODE_INFRAME;
            end
            hdb_pkg::MODE_DISCARD:
            begin
                if (is_flag)
                begin
                    mode_next = hdb_pkg::MODE_UNSYNCED;
                end
            end
            default:
            begin
                mode_next = hdb_pkg::MODE_UNSYNCED;
            end
        endcase
    end

    // Result and counter update
    always_comb
    begin
        result.event_res    = hdb_pkg::EV_NONE;
        result.payload_byte = '0;
        result.byte_index   = '0;
        result.frame_length = '0;
        count_next          = count_reg;
        case (mode_reg)
            hdb_pkg::MODE_UNSYNCED, hdb_pkg::MODE_DISCARD:
            begin
                if (is_flag)
                begin
                    count_next = '0;
                end
            end
            hdb_pkg::MODE_SYNCED, hdb_pkg::MODE_INFRAME, hdb_pkg::MODE_ESCAPE:
            begin
                if (mode_reg != hdb_pkg::MODE_ESCAPE && is_flag)
                begin
                    if (mode_reg == hdb_pkg::MODE_INFRAME)
                    begin
                        result.event_res    = hdb_pkg::EV_END;
                        result.frame_length = count_reg;
                        count_next          = '0;
                    end
                end
                else if (mode_reg != hdb_pkg::MODE_ESCAPE && is_esc)
                begin
                    count_next = count_reg;
                end
                else if (full)
                begin
                    result.event_res = hdb_pkg::EV_OVERFLOW;
                end
                else
                begin
                    result.event_res    = hdb_pkg::EV_PAYLOAD;
                    result.payload_byte = data_byte;
                    result.byte_index   = count_reg[hdb_pkg::INDEX_W-1:0];
                    count_next          = count_reg + 1'b1;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    // Mode and count registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= hdb_pkg::MODE_UNSYNCED;
            count_reg <= '0;
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
        end
    end

    // Length limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= hdb_pkg::COUNT_W'(4096);
        end
        else if (cfg_wr_en)
        begin
            max_len_reg <= cfg_wr_data;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/hdb_out_stage.sv
// ----------------------------------------------------------------------------
// hdb_out_stage: result register of the receiver
// Holds one result until the downstream side takes the transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module hdb_out_stage (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire hdb_pkg::result_t result,
    output logic                  out_free,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [39:0]           m_tdata,
    output logic [1:0]            m_tuser
);

    logic             valid_reg;
    logic             valid_next;
    hdb_pkg::result_t res_reg;

    assign out_free = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;

    // Pack fields, zero pad highest and payload byte lowest
    assign m_tdata = {7'd0, res_reg.frame_length, res_reg.byte_index, res_reg.payload_byte};
    assign m_tuser = res_reg.event_res;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    // Occupancy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Result holding register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= result;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/hdlc_byte_destuff_receiver_top.sv
// ----------------------------------------------------------------------------
// hdlc_byte_destuff_receiver_top: asynchronous HDLC byte destuffing receiver
// Deframes a flag/escape stuffed byte stream, one byte per transfer.
// ----------------------------------------------------------------------------
// Each input transfer carries one raw byte and produces exactly one output
// transfer: tuser gives the event (0 nothing, 1 payload byte with its index,
// 2 frame end with its length, 3 overflow abort). The block takes one byte
// every clock cycle when the output is not stalled; each byte is held in the
// input register and its result is then registered in the output register.
// cfg_wr_data sets the payload length limit (clamped to MAX_FRAME); the user
// must see it is written only while the block is idle, as it is not enforced.
`default_nettype none

module hdlc_byte_destuff_receiver_top #(
    parameter int unsigned MAX_FRAME = hdb_pkg::MAX_FRAME_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,      // [7:0] rx_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,      // [7:0] payload_byte, [19:8] byte_index,
                                           // [32:20] frame_length, [39:33] zero
    output logic [1:0]       m_tuser,      // [1:0] event_res
    input  wire logic        cfg_wr_en,
    input  wire logic [12:0] cfg_wr_data   // max_length
);

    logic             step;
    logic             out_free;
    logic [7:0]       rx_byte;
    hdb_pkg::result_t result;

    // Input register
    hdb_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .out_free (out_free),
        .step     (step),
        .rx_byte  (rx_byte)
    );

    // Mode machine and counter
    hdb_deframer #(
        .MAX_FRAME (MAX_FRAME)
    ) u_deframer (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .rx_byte     (rx_byte),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .result      (result)
    );

    // Result register
    hdb_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (step),
        .result   (result),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

FILE: sim/tb_hdlc_byte_destuff_receiver_top.sv
// ----------------------------------------------------------------------------
// tb_hdlc_byte_destuff_receiver_top: self-checking bench for the HDLC destuffer
// Feeds stuffed byte streams (directed corner cases, random frames and noise)
// under several length limits. A behavioral predictor computes the event of
// every accepted byte, and each output transfer is compared field by field
// against the oldest predicted event.
// ----------------------------------------------------------------------------
module tb_hdlc_byte_destuff_receiver_top;

    localparam int unsigned LATENCY   = 2;
    localparam int          SEG_BYTES = 185;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata     = '0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_wr_en   = 1'b0;
    logic [12:0] cfg_wr_data = '0;

    // Pending raw bytes and predicted events
    logic [7:0]          raw_byte_q[$];
    hdb_pkg::result_t    event_q[$];

    int errors       = 0;
    int bytes_queued = 0;
    int tx_gap_pct   = 17;
    int rx_stall_pct = 52;

    // Predictor state
    hdb_pkg::rx_mode_t pred_mode  = hdb_pkg::MODE_UNSYNCED;
    logic [12:0]       pred_count = '0;
    logic [12:0]       pred_limit = 13'(hdb_pkg::MAX_FRAME_DEF);

    hdlc_byte_destuff_receiver_top uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Payload byte or overflow abort, limit clamped to the frame size
    function automatic hdb_pkg::result_t accept_payload(input logic [7:0] b);
        hdb_pkg::result_t r;
        logic [12:0]      lim;
        r   = '0;
        lim = (pred_limit > hdb_pkg::MAX_FRAME_DEF) ? 13'(hdb_pkg::MAX_FRAME_DEF)
                                                    : pred_limit;
        if (pred_count >= lim)
        begin
            pred_mode   = hdb_pkg::MODE_DISCARD;
            r.event_res = hdb_pkg::EV_OVERFLOW;
        end
        else
        begin
            r.event_res    = hdb_pkg::EV_PAYLOAD;
            r.payload_byte = b;
            r.byte_index   = pred_count[11:0];
            pred_count     = pred_count + 13'd1;
            pred_mode      = hdb_pkg::MODE_INFRAME;
        end
        return r;
    endfunction

    // Event caused by one raw byte
    function automatic hdb_pkg::result_t predict_event(input logic [7:0] b);
        hdb_pkg::result_t r;
        r = '0;
        case (pred_mode)
            hdb_pkg::MODE_UNSYNCED:
                if (b == hdb_pkg::FLAG_BYTE)
                begin
                    pred_count = '0;
                    pred_mode  = hdb_pkg::MODE_SYNCED;
                end
            hdb_pkg::MODE_SYNCED, hdb_pkg::MODE_INFRAME:
                if (b == hdb_pkg::FLAG_BYTE)
                begin
                    // repeated flags while synced are skipped
                    if (pred_mode == hdb_pkg::MODE_INFRAME)
                    begin
                        r.event_res    = hdb_pkg::EV_END;
                        r.frame_length = pred_count;
                        pred_count     = '0;
                        pred_mode      = hdb_pkg::MODE_UNSYNCED;
                    end
                end
                else if (b == hdb_pkg::ESC_BYTE)
                    pred_mode = hdb_pkg::MODE_ESCAPE;
                else
                    r = accept_payload(b);
            hdb_pkg::MODE_ESCAPE:
                r = accept_payload(b ^ hdb_pkg::ESC_XOR);
            hdb_pkg::MODE_DISCARD:
                if (b == hdb_pkg::FLAG_BYTE)
                begin
                    pred_count = '0;
                    pred_mode  = hdb_pkg::MODE_UNSYNCED;
                end
            default:
                pred_mode = hdb_pkg::MODE_UNSYNCED;
        endcase
        return r;
    endfunction

    // Byte source: predicts on every accepted transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                event_q.push_back(predict_event(s_tdata));
            if (!s_tvalid || s_tready)
            begin
                if (raw_byte_q.size() != 0 && $urandom_range(99) >= tx_gap_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= raw_byte_q.pop_front();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Event sink and checker
    always @(posedge clk or negedge rst_n)
    begin : event_check
        hdb_pkg::result_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (event_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected transfer: ev=%0d data=%h", $time, m_tuser, m_tdata);
                end
                else
                begin
                    want = event_q.pop_front();
                    if (m_tuser !== want.event_res || m_tdata[7:0] !== want.payload_byte ||
                        m_tdata[19:8] !== want.byte_index ||
                        m_tdata[32:20] !== want.frame_length || m_tdata[39:33] !== '0)
                    begin
                        errors++;
                        $display("%0t: mismatch: expected ev=%0d byte=%h idx=%0d len=%0d",
                                 $time, want.event_res, want.payload_byte,
                                 want.byte_index, want.frame_length);
                        $display("%0t:           actual   ev=%0d byte=%h idx=%0d len=%0d pad=%h",
                                 $time, m_tuser, m_tdata[7:0], m_tdata[19:8],
                                 m_tdata[32:20], m_tdata[39:33]);
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    task automatic queue_byte(input logic [7:0] b);
        raw_byte_q.push_back(b);
        bytes_queued++;
    endtask

    // Stuff one payload byte; ordinary bytes are escaped now and then too
    task automatic queue_payload(input logic [7:0] b);
        if (b == hdb_pkg::FLAG_BYTE || b == hdb_pkg::ESC_BYTE || $urandom_range(19) == 0)
        begin
            queue_byte(hdb_pkg::ESC_BYTE);
            queue_byte(b ^ hdb_pkg::ESC_XOR);
        end
        else
            queue_byte(b);
    endtask

    // Block is idle: nothing queued, in flight or outstanding
    task automatic wait_idle();
        do
            @(negedge clk);
        while (raw_byte_q.size() != 0 || s_tvalid || event_q.size() != 0);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_limit(input logic [12:0] v);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        pred_limit  = v;
    endtask

    // Mostly well-formed frames with random content, the rest noise
    task automatic random_segment(input int n_bytes);
        int         start;
        int         plen;
        int         lim;
        logic [7:0] b;
        start = bytes_queued;
        lim   = (pred_limit > hdb_pkg::MAX_FRAME_DEF) ? hdb_pkg::MAX_FRAME_DEF : pred_limit;
        while (bytes_queued - start < n_bytes)
        begin
            if ($urandom_range(99) < 82)
            begin
                repeat ($urandom_range(1, 3)) queue_byte(hdb_pkg::FLAG_BYTE);
                plen = (lim < 30) ? $urandom_range(0, lim + 2) : $urandom_range(0, 30);
                for (int i = 0; i < plen; i++)
                begin
                    case ($urandom_range(15))
                        0:       b = hdb_pkg::FLAG_BYTE;
                        1:       b = hdb_pkg::ESC_BYTE;
                        default: b = 8'($urandom);
                    endcase
                    queue_payload(b);
                end
                // sometimes leave the frame open
                if ($urandom_range(9) != 0)
                    queue_byte(hdb_pkg::FLAG_BYTE);
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                begin
                    case ($urandom_range(3))
                        0:       queue_byte(hdb_pkg::FLAG_BYTE);
                        1:       queue_byte(hdb_pkg::ESC_BYTE);
                        default: queue_byte(8'($urandom));
                    endcase
                end
            end
        end
    endtask

    initial
    begin : stimulus
        // escapes, escaped flag, flag after escape, ignored bytes while unsynced
        logic [7:0]  dir_basic [16];
        // zero limit: overflow, discard ends at flag into unsynced
        logic [7:0]  dir_zero [8];
        logic [12:0] seg_limit [6];
        dir_basic = '{hdb_pkg::FLAG_BYTE, hdb_pkg::FLAG_BYTE, 8'h00, 8'hFF,
                      hdb_pkg::ESC_BYTE, hdb_pkg::FLAG_BYTE ^ hdb_pkg::ESC_XOR,
                      hdb_pkg::ESC_BYTE, hdb_pkg::ESC_BYTE ^ hdb_pkg::ESC_XOR,
                      hdb_pkg::ESC_BYTE, hdb_pkg::FLAG_BYTE, hdb_pkg::FLAG_BYTE, 8'h55,
                      hdb_pkg::ESC_BYTE, hdb_pkg::FLAG_BYTE, 8'h31, hdb_pkg::FLAG_BYTE};
        dir_zero  = '{hdb_pkg::FLAG_BYTE, 8'h12, hdb_pkg::FLAG_BYTE, 8'h41,
                      hdb_pkg::FLAG_BYTE, hdb_pkg::ESC_BYTE, 8'h31, hdb_pkg::FLAG_BYTE};
        seg_limit = '{13'd3, 13'd4096, 13'h1FFF, 13'($urandom_range(4, 40)), 13'd0, 13'd1};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_basic[i]) queue_byte(dir_basic[i]);
        write_limit(13'd0);
        foreach (dir_zero[i]) queue_byte(dir_zero[i]);

        // limit lowered below the count in the middle of a frame
        write_limit(13'd5);
        queue_byte(hdb_pkg::FLAG_BYTE);
        queue_byte(8'h61);
        queue_byte(8'h62);
        queue_byte(8'h63);
        write_limit(13'd1);
        queue_byte(8'h64);
        queue_byte(hdb_pkg::FLAG_BYTE);

        for (int s = 0; s < 6; s++)
        begin
            write_limit(seg_limit[s]);
            if (s < 2)
            begin
                tx_gap_pct   = 17;
                rx_stall_pct = 52;
            end
            else if (s < 4)
            begin
                tx_gap_pct   = 52;
                rx_stall_pct = 17;
            end
            else
            begin
                tx_gap_pct   = 0;
                rx_stall_pct = 0;
            end
            random_segment(SEG_BYTES);
        end

        wait_idle();
        repeat (10) @(posedge clk);
        if (errors == 0 && event_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
